// ===== hw/rtl/csk_pkg.sv =====
package csk_pkg;

    localparam int VAL_W   = 16;
    localparam int DEN_W   = VAL_W + 1;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int QUO_W   = VAL_W;
    localparam int SUM_W   = 34;
    localparam int OUT_W   = 36;
    localparam int N_CELLS = QUO_W;

    localparam logic [OUT_W-1:0] ONE_Q15 = OUT_W'(32768);

    typedef logic [VAL_W-1:0]  t_value;
    typedef logic [DEN_W-1:0]  t_den;
    typedef logic [PROD_W-1:0] t_prod;
    typedef logic [QUO_W-1:0]  t_quo;
    typedef logic [SUM_W-1:0]  t_sum;
    typedef logic [OUT_W-1:0]  t_out;

    typedef struct packed {
        logic   last;
        t_den   den;
        t_den   rem;
        t_value num_lo;
        t_quo   quo;
    } t_div_word;

endpackage

// ===== hw/rtl/chi_square_kernel_dense.sv =====
// A last pair passes the prep registers, the divider cells and the output register before its result is on o_valid.
// Throughput: one element pair per cycle; the flow holds only while a result
// waits in the output register under i_stall.
// Path: absolute difference, square, a chain of 16 restoring divider cells
// (one quotient bit each), then the saturating accumulator.
// Reset: synchronous, active low; empties the pipe and clears the sum and flag.
module chi_square_kernel_dense (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [csk_pkg::VAL_W-1:0]      i_x_value,
    input  logic [csk_pkg::VAL_W-1:0]      i_y_value,
    input  logic                           i_last_element,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic signed [csk_pkg::OUT_W-1:0] o_similarity,
    output logic                           o_saturated
);
    import csk_pkg::*;

    logic      adv;
    logic      cell_valid [0:N_CELLS];
    t_div_word cell_word  [0:N_CELLS];
    t_out      similarity;

    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    csk_prep u_prep (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv),
        .i_valid        (i_valid),
        .i_x_value      (i_x_value),
        .i_y_value      (i_y_value),
        .i_last_element (i_last_element),
        .o_valid        (cell_valid[0]),
        .o_word         (cell_word[0])
    );

    for (genvar g = 0; g < N_CELLS; g++) begin : g_cell
        csk_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_valid (cell_valid[g]),
            .i_word  (cell_word[g]),
            .o_valid (cell_valid[g+1]),
            .o_word  (cell_word[g+1])
        );
    end

    csk_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_stall      (i_stall),
        .i_valid      (cell_valid[N_CELLS]),
        .i_word       (cell_word[N_CELLS]),
        .o_valid      (o_valid),
        .o_similarity (similarity),
        .o_saturated  (o_saturated)
    );

    assign o_similarity = similarity;

`ifndef NO_ASSERTIONS
    a_even_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_similarity[0])
        else $error("odd similarity value");

    a_upper_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_similarity <= OUT_W'(32768)) && !o_similarity[OUT_W-1]
            || o_valid && o_similarity[OUT_W-1])
        else $error("similarity above one");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !cell_valid[N_CELLS])
        else $error("pipe not empty after reset");

    a_unsat_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_similarity[OUT_W-1])
        else $error("saturated result not negative");
`endif

endmodule

// ===== hw/rtl/csk_prep.sv =====
module csk_prep (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  csk_pkg::t_value    i_x_value,
    input  csk_pkg::t_value    i_y_value,
    input  logic               i_last_element,
    output logic               o_valid,
    output csk_pkg::t_div_word o_word
);
    import csk_pkg::*;

    logic   r_valid_a;
    logic   r_last_a;
    t_value r_diff_a;
    t_den   r_den_a;
    logic   r_valid_b;
    logic   r_last_b;
    t_den   r_den_b;
    t_prod  r_prod_b;
    t_value n_diff;
    t_den   n_den;

    always_comb begin
        n_diff = (i_x_value >= i_y_value) ? (i_x_value - i_y_value) : (i_y_value - i_x_value);
        n_den  = DEN_W'(i_x_value) + DEN_W'(i_y_value);
        // zero denominator only with zero numerator: divide by one for a zero term
        if (n_den == '0) begin
            n_den = DEN_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else if (i_adv) begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_last_a <= i_last_element;
            r_diff_a <= n_diff;
            r_den_a  <= n_den;
            r_last_b <= r_last_a;
            r_den_b  <= r_den_a;
            r_prod_b <= PROD_W'(r_diff_a) * PROD_W'(r_diff_a);
        end
    end

    assign o_valid       = r_valid_b;
    assign o_word.last   = r_last_b;
    assign o_word.den    = r_den_b;
    assign o_word.rem    = DEN_W'(r_prod_b[PROD_W-1:VAL_W]);
    assign o_word.num_lo = r_prod_b[VAL_W-1:0];
    assign o_word.quo    = '0;

endmodule

// ===== hw/rtl/csk_div_cell.sv =====
module csk_div_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_valid,
    input  csk_pkg::t_div_word i_word,
    output logic               o_valid,
    output csk_pkg::t_div_word o_word
);
    import csk_pkg::*;

    logic                 r_valid;
    t_div_word            r_word;
    t_div_word            n_word;
    logic [DEN_W:0]       trial;
    logic                 ge;

    always_comb begin
        trial         = {i_word.rem, i_word.num_lo[VAL_W-1]};
        ge            = trial >= {1'b0, i_word.den};
        n_word        = i_word;
        n_word.rem    = ge ? DEN_W'(trial - {1'b0, i_word.den}) : DEN_W'(trial);
        n_word.num_lo = {i_word.num_lo[VAL_W-2:0], 1'b0};
        n_word.quo    = {i_word.quo[QUO_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

// ===== hw/rtl/csk_accum.sv =====
module csk_accum (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  logic               i_stall,
    input  logic               i_valid,
    input  csk_pkg::t_div_word i_word,
    output logic               o_valid,
    output csk_pkg::t_out      o_similarity,
    output logic               o_saturated
);
    import csk_pkg::*;

    t_sum             r_sum;
    logic             r_sat;
    logic             r_out_valid;
    t_out             r_similarity;
    logic             r_out_sat;
    logic [SUM_W:0]   wide_sum;
    t_sum             n_sum;
    logic             n_sat;

    always_comb begin
        wide_sum = {1'b0, r_sum} + (SUM_W+1)'(i_word.quo);
        n_sum    = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
        n_sat    = r_sat | wide_sum[SUM_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_adv && i_valid) begin
                r_sum <= i_word.last ? '0 : n_sum;
                r_sat <= i_word.last ? 1'b0 : n_sat;
            end
            if (i_adv && i_valid && i_word.last) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid && i_word.last) begin
            r_similarity <= ONE_Q15 - {1'b0, n_sum, 1'b0};
            r_out_sat    <= n_sat;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_similarity = r_similarity;
    assign o_saturated  = r_out_sat;

endmodule
